[hdl/binary_range_encoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Binary range encoder assertion macros
// Concurrent check wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_RANGE_ENCODER_UNIT_DEFINES_SVH
`define BINARY_RANGE_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define BRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRC_ASSERT_ALWAYS(lbl, cond, msg)
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/brc_pkg.sv]
// ----------------------------------------------------------------------------
// Binary range encoder package
// Shared types, opcodes and constants of the range encoder.
// ----------------------------------------------------------------------------
package brc_pkg;

    localparam logic [1:0] OP_CODE    = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [32:0] TOP_LIMIT     = 33'h0_ff00_0000;
    localparam logic [31:0] RENORM_LIMIT  = 32'h0100_0000;
    localparam logic [2:0]  FLUSH_SHIFTS  = 3'd5;
    localparam logic [2:0]  MAX_RESULTS   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_RENORM,
        ST_FLUSH,
        ST_FINISH
    } brc_state_t;

    // Sequencer commands to the coder datapath.
    typedef struct packed {
        logic load;
        logic restart;
        logic mul;
        logic upd;
        logic shift;
        logic range_shift;
    } brc_cmd_t;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic renorm_need;
        logic release_byte;
    } brc_stat_t;

    // Sequencer commands to the output stage.
    typedef struct packed {
        logic push;
        logic drain;
    } brc_ocmd_t;

    // Output stage status back to the sequencer.
    typedef struct packed {
        logic hold_valid;
        logic out_free;
    } brc_ostat_t;

    typedef struct packed {
        logic        lead_valid;
        logic [7:0]  lead_byte;
        logic [31:0] fill_count;
        logic        fill_carry;
    } brc_result_t;

endpackage

[hdl/brc_core.sv]
// ----------------------------------------------------------------------------
// Binary range encoder datapath
// Coder state, the shared bound multiplier and the byte shifter.
// ----------------------------------------------------------------------------
`include "binary_range_encoder_unit_defines.svh"

module brc_core
    import brc_pkg::*;
#(
    parameter int PROB_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  brc_cmd_t    cmd,
    input  logic [12:0] probability,
    input  logic        coded_bit,
    output brc_stat_t   stat,
    output brc_result_t result
);

    localparam int PW = (PROB_BITS > 13) ? PROB_BITS : 13;
    localparam logic [PW-1:0] PMAX = PW'((1 << PROB_BITS) - 1);
    localparam logic [PW-1:0] PMIN = PW'(1);

    logic [32:0]    low_reg;
    logic [31:0]    range_reg;
    logic [7:0]     cache_reg;
    logic [31:0]    pend_reg;
    logic           first_reg;
    logic [PW-1:0]  prob_reg;
    logic           bit_reg;
    logic [31:0]    bound_reg;

    logic [PW-1:0]      prob_ext;
    logic [PW-1:0]      prob_clamped;
    logic [32+PW-1:0]   product;
    logic               carry;

    assign prob_ext = PW'(probability);

    always_comb
    begin
        priority if (prob_ext == '0)
            prob_clamped = PMIN;
        else if (prob_ext > PMAX)
            prob_clamped = PMAX;
        else
            prob_clamped = prob_ext;
    end

    assign product = {{PW{1'b0}}, range_reg} * {32'd0, prob_reg};

    assign carry             = low_reg[32];
    assign stat.release_byte = (low_reg < TOP_LIMIT) || carry;
    assign stat.renorm_need  = range_reg < RENORM_LIMIT;

    assign result.lead_valid = !first_reg;
    assign result.lead_byte  = first_reg ? 8'd0 : (cache_reg + {7'd0, carry});
    assign result.fill_count = pend_reg;
    assign result.fill_carry = carry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '0;
            range_reg <= '1;
            cache_reg <= '0;
            pend_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.restart)
        begin
            low_reg   <= '0;
            range_reg <= '1;
            cache_reg <= '0;
            pend_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.upd)
        begin
            if (bit_reg)
            begin
                range_reg <= bound_reg;
            end
            else
            begin
                low_reg   <= low_reg + {1'b0, bound_reg};
                range_reg <= range_reg - bound_reg;
            end
        end
        else if (cmd.shift)
        begin
            if (cmd.range_shift)
                range_reg <= {range_reg[23:0], 8'h00};
            // A released byte ends the pending run; otherwise the run of 0xff grows.
            if (stat.release_byte)
            begin
                first_reg <= 1'b0;
                pend_reg  <= '0;
                cache_reg <= low_reg[31:24];
            end
            else
            begin
                pend_reg <= pend_reg + 32'd1;
            end
            low_reg <= {1'b0, low_reg[23:0], 8'h00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prob_reg <= prob_clamped;
            bit_reg  <= coded_bit;
        end
        if (cmd.mul)
            bound_reg <= product[PROB_BITS +: 32];
    end

    `BRC_ASSERT_ALWAYS(a_range_nonzero, range_reg != 32'd0, "range collapsed to zero")
    `BRC_ASSERT_NEXT(a_upd_range_nonzero, cmd.upd, range_reg != 32'd0, "update left empty range")

endmodule

[hdl/brc_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary range encoder sequencer
// Steps one item through multiply, update and byte shifts.
// ----------------------------------------------------------------------------
`include "binary_range_encoder_unit_defines.svh"

module brc_ctrl
    import brc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  brc_stat_t   stat,
    input  brc_ostat_t  ostat,
    output brc_cmd_t    cmd,
    output brc_ocmd_t   ocmd
);

    brc_state_t state_reg;
    brc_state_t state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       stall;
    logic       renorm_more;

    // A released byte needs the hold stage to make room before it is shifted out.
    assign stall       = stat.release_byte && ostat.hold_valid && !ostat.out_free;
    assign renorm_more = stat.renorm_need && (cnt_reg < MAX_RESULTS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_CODE)
                        state_next = ST_MUL;
                    else if (opcode == OP_FLUSH)
                        state_next = ST_FLUSH;
                end
            end
            ST_MUL:    state_next = ST_UPD;
            ST_UPD:    state_next = ST_RENORM;
            ST_RENORM:
            begin
                if (!renorm_more)
                    state_next = ST_FINISH;
            end
            ST_FLUSH:
            begin
                if (cnt_reg >= FLUSH_SHIFTS)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!ostat.hold_valid || ostat.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        ocmd     = '0;
        cnt_next = cnt_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.load    = (opcode == OP_CODE);
                    cmd.restart = (opcode == OP_RESTART);
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
            end
            ST_RENORM:
            begin
                // Here the counter tracks results given by this item.
                if (renorm_more && !stall)
                begin
                    cmd.shift       = 1'b1;
                    cmd.range_shift = 1'b1;
                    if (stat.release_byte)
                    begin
                        ocmd.push = 1'b1;
                        cnt_next  = cnt_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                // Here the counter tracks byte shifts.
                if ((cnt_reg < FLUSH_SHIFTS) && !stall)
                begin
                    cmd.shift = 1'b1;
                    ocmd.push = stat.release_byte;
                    cnt_next  = cnt_reg + 3'd1;
                end
            end
            ST_FINISH:
            begin
                ocmd.drain = ostat.hold_valid && ostat.out_free;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `BRC_ASSERT_ALWAYS(a_no_dropped_result, !(cmd.shift && stall), "shift over a blocked result")
    `BRC_ASSERT_ALWAYS(a_idle_hold_empty, !(in_ready && ostat.hold_valid), "idle with held result")

endmodule

[hdl/brc_out.sv]
// ----------------------------------------------------------------------------
// Binary range encoder output stage
// Holds one result until the next decides whether it is the last.
// ----------------------------------------------------------------------------
`include "binary_range_encoder_unit_defines.svh"

module brc_out
    import brc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  brc_ocmd_t   ocmd,
    input  brc_result_t result,
    output brc_ostat_t  ostat,
    output logic        out_valid,
    input  logic        out_ready,
    output brc_result_t out_result,
    output logic        out_last
);

    logic        hold_valid_reg;
    brc_result_t hold_reg;
    logic        out_valid_reg;
    brc_result_t out_reg;
    logic        last_reg;
    logic        move;

    assign ostat.hold_valid = hold_valid_reg;
    assign ostat.out_free   = !out_valid_reg || out_ready;
    assign move             = (ocmd.push && hold_valid_reg) || ocmd.drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ocmd.push)
                hold_valid_reg <= 1'b1;
            else if (ocmd.drain)
                hold_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ocmd.push)
            hold_reg <= result;
        if (move)
        begin
            out_reg  <= hold_reg;
            last_reg <= ocmd.drain;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_last   = last_reg;

    `BRC_ASSERT_ALWAYS(a_push_drain_excl, !(ocmd.push && ocmd.drain), "push and drain together")
    `BRC_ASSERT_ALWAYS(a_move_has_room, !(move && !ostat.out_free), "output overwritten")

endmodule

[hdl/binary_range_encoder_unit.sv]
// Sequence: a coded bit runs from acceptance through MUL, UPD and RENORM, whose byte
// shifts push results, to FINISH, which moves any held result into the output register;
// a flush runs through FLUSH and FINISH. Throughput: a new item is taken only in IDLE,
// a restart or unused opcode every cycle; coded bits and flushes are paced by the shared
// bound multiplier and single byte shifter under the sequencer, plus output back-pressure.
// Reset: rst_n is asynchronous, active low, and returns the coder to its restart state.
// ----------------------------------------------------------------------------
// Binary range encoder unit
// Carry-propagating binary range coder with clamped probabilities.
// ----------------------------------------------------------------------------
module binary_range_encoder_unit
    import brc_pkg::*;
#(
    parameter int PROB_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [12:0] probability,
    input  logic        coded_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        lead_valid,
    output logic [7:0]  lead_byte,
    output logic [31:0] fill_count,
    output logic        fill_carry,
    output logic        last
);

    brc_cmd_t    cmd;
    brc_stat_t   stat;
    brc_ocmd_t   ocmd;
    brc_ostat_t  ostat;
    brc_result_t result;
    brc_result_t out_result;

    brc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .ostat    (ostat),
        .cmd      (cmd),
        .ocmd     (ocmd)
    );

    brc_core #(
        .PROB_BITS (PROB_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .probability (probability),
        .coded_bit   (coded_bit),
        .stat        (stat),
        .result      (result)
    );

    brc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ocmd       (ocmd),
        .result     (result),
        .ostat      (ostat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .out_last   (last)
    );

    assign lead_valid = out_result.lead_valid;
    assign lead_byte  = out_result.lead_byte;
    assign fill_count = out_result.fill_count;
    assign fill_carry = out_result.fill_carry;

endmodule
